FILE: rtl/pcpd_pkg.sv
// ----------------------------------------------------------------------------
// pcpd_pkg: shared types and constants of the pixel column peak decimator
// sample widths, request and result records, command codes, back end states
// ----------------------------------------------------------------------------
package pcpd_pkg;

	localparam int SAMPLE_BITS = 32;
	localparam int FRAC_BITS   = 16;
	localparam int SCALE_W     = 32;
	localparam int CFG_W       = (SAMPLE_BITS > SCALE_W) ? SAMPLE_BITS : SCALE_W;
	localparam int REG_IDX_W   = 2;

	// bin magnitude reaches 2^SAMPLE_BITS on the negative side
	localparam int BIN_W  = SAMPLE_BITS + 1;
	// product widths of the two scalings
	localparam int PF_W   = SAMPLE_BITS + SCALE_W;
	localparam int PB_W   = BIN_W + SCALE_W;
	// rounded product widths
	localparam int RF_W   = PF_W + 1 - FRAC_BITS;
	localparam int RB_W   = PB_W + 1 - FRAC_BITS;
	// saturated column offset magnitude, up to 2^(SAMPLE_BITS+1)
	localparam int CXM_W  = SAMPLE_BITS + 2;
	localparam int CXS_W  = SAMPLE_BITS + 3;

	localparam logic [BIN_W-1:0] BIN_LIM_POS = {1'b0, {SAMPLE_BITS{1'b1}}};
	localparam logic [BIN_W-1:0] BIN_LIM_NEG = {1'b1, {SAMPLE_BITS{1'b0}}};
	localparam logic [CXM_W-1:0] COLX_LIM    = {1'b1, {(SAMPLE_BITS + 1){1'b0}}};

	localparam logic [PF_W:0] HALF_F = {{(PF_W + 1 - FRAC_BITS){1'b0}}, 1'b1,
		{(FRAC_BITS - 1){1'b0}}};
	localparam logic [PB_W:0] HALF_B = {{(PB_W + 1 - FRAC_BITS){1'b0}}, 1'b1,
		{(FRAC_BITS - 1){1'b0}}};

	localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(65536);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// request kinds
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_START  = 2'd1;
	localparam logic [1:0] KIND_FLUSH  = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_X_ORIGIN  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BIN_SCALE = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BIN_STEP  = 2'd2;

	// result status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_DROP = 1'b1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t            origin;
		logic [SCALE_W-1:0] scale;
		logic [SCALE_W-1:0] step;
	} cfg_t;

	// classified request: bin in sign and magnitude form, minus zero never appears
	typedef struct packed {
		logic [1:0]       kind;
		sample_t          x;
		sample_t          y;
		logic             bin_neg;
		logic [BIN_W-1:0] bin_mag;
	} cmd_t;

	typedef struct packed {
		logic    point_valid;
		sample_t point_x;
		sample_t point_y;
		logic    last;
		logic    status;
		sample_t seen_min_x;
		sample_t seen_max_x;
		sample_t seen_min_y;
		sample_t seen_max_y;
	} result_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_EMIT1,
		B_EMIT2,
		B_MUL,
		B_RND,
		B_COLX
	} back_state_t;

endpackage

FILE: rtl/pcpd_front.sv
// ----------------------------------------------------------------------------
// pcpd_front: request intake and pixel bin computation
// two register stages: offset from origin, then scaling; rounding at the push
// ----------------------------------------------------------------------------
module pcpd_front import pcpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  sample_t    x_value,
	input  sample_t    y_value,
	output logic       q_push,
	output cmd_t       q_wdata,
	input  logic       q_ready
);

	logic                   adv;
	logic [SAMPLE_BITS:0]   d_pos;
	logic [SAMPLE_BITS:0]   d_rev;

	logic                   v_s1;
	logic [1:0]             kind_s1;
	sample_t                x_s1;
	sample_t                y_s1;
	logic                   neg_s1;
	logic [SAMPLE_BITS-1:0] mag_s1;

	logic                   v_s2;
	logic [1:0]             kind_s2;
	sample_t                x_s2;
	sample_t                y_s2;
	logic                   neg_s2;
	logic [PF_W-1:0]        prod_s2;

	logic [PF_W:0]          rsum;
	logic [RF_W-1:0]        rval;
	logic [BIN_W-1:0]       lim;
	logic [BIN_W-1:0]       bmag;

	assign adv      = !v_s2 || q_ready;
	assign in_ready = adv;

	// both differences side by side, sign of the first picks the magnitude
	assign d_pos = {x_value[SAMPLE_BITS-1], x_value} - {cfg.origin[SAMPLE_BITS-1], cfg.origin};
	assign d_rev = {cfg.origin[SAMPLE_BITS-1], cfg.origin} - {x_value[SAMPLE_BITS-1], x_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind;
			x_s1    <= x_value;
			y_s1    <= y_value;
			neg_s1  <= d_pos[SAMPLE_BITS];
			mag_s1  <= d_pos[SAMPLE_BITS] ? d_rev[SAMPLE_BITS-1:0] : d_pos[SAMPLE_BITS-1:0];
			kind_s2 <= kind_s1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			neg_s2  <= neg_s1;
			prod_s2 <= PF_W'(mag_s1) * PF_W'(cfg.scale);
		end
	end

	// round half away from zero on the magnitude, then clamp to the bin range
	always_comb begin
		rsum = {1'b0, prod_s2} + HALF_F;
		rval = rsum[PF_W:FRAC_BITS];
		lim  = neg_s2 ? BIN_LIM_NEG : BIN_LIM_POS;
		if (rval > RF_W'(lim)) begin
			bmag = lim;
		end else begin
			bmag = rval[BIN_W-1:0];
		end
		q_wdata.kind    = kind_s2;
		q_wdata.x       = x_s2;
		q_wdata.y       = y_s2;
		q_wdata.bin_neg = neg_s2 && (bmag != '0);
		q_wdata.bin_mag = bmag;
	end

	assign q_push = v_s2 && q_ready;

endmodule

FILE: rtl/pcpd_queue.sv
// ----------------------------------------------------------------------------
// pcpd_queue: short request queue between front and back end
// register based; while it is not full and not empty, one write and one read per cycle
// ----------------------------------------------------------------------------
module pcpd_queue import pcpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic ready,
	output logic valid,
	output cmd_t rdata,
	input  logic pop
);

	cmd_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign ready = count_q != QCNT_W'(QDEPTH);
	assign valid = count_q != '0;
	assign rdata = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != QCNT_W'(QDEPTH)))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue read while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == QCNT_W'($past(count_q) + 1'b1)))
		else $error("queue fill count lost a write");

endmodule

FILE: rtl/pcpd_back.sv
// ----------------------------------------------------------------------------
// pcpd_back: series state, column tracking and result sequencing
// owns the output register; column x is set in three steps on column open or change
// ----------------------------------------------------------------------------
module pcpd_back import pcpd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    q_valid,
	input  cmd_t    q_data,
	output logic    q_pop,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t res
);

	back_state_t      state_q, state_d;

	logic             fresh_q;
	logic             open_q;
	logic             chg_q;
	sample_t          prev_x_q;
	logic             col_neg_q;
	logic [BIN_W-1:0] col_mag_q;
	sample_t          col_x_q;
	sample_t          col_peak_q;
	sample_t          pend_y_q;
	sample_t          min_x_q, max_x_q, min_y_q, max_y_q;
	logic [PB_W-1:0]  prod_q;
	logic [CXM_W-1:0] sat_q;

	logic             out_valid_q;
	result_t          res_q;
	result_t          res_d;
	logic             load;
	logic             out_free;
	logic             peak_commit;

	logic             k_sample;
	logic             x_lt_prev;
	logic             same_bin;
	logic             do_open, do_err, do_peak, do_change, do_flush, do_start;
	sample_t          min_x_d, max_x_d, min_y_d, max_y_d;
	logic             use_new_ext;

	logic [PB_W:0]    rsum;
	logic [RB_W-1:0]  rval;
	logic [CXS_W-1:0] org_ext;
	logic [CXS_W-1:0] off_ext;
	logic [CXS_W-1:0] colx_sum;
	logic             colx_fits;
	sample_t          colx_d;

	assign out_valid = out_valid_q;
	assign res       = res_q;

	// decode of the request at the queue head
	always_comb begin
		k_sample  = q_data.kind == KIND_SAMPLE;
		x_lt_prev = q_data.x < prev_x_q;
		same_bin  = (q_data.bin_neg == col_neg_q) && (q_data.bin_mag == col_mag_q);

		if (fresh_q) begin
			min_x_d = q_data.x;
			max_x_d = q_data.x;
			min_y_d = q_data.y;
			max_y_d = q_data.y;
		end else begin
			min_x_d = (q_data.x < min_x_q) ? q_data.x : min_x_q;
			max_x_d = (q_data.x > max_x_q) ? q_data.x : max_x_q;
			min_y_d = (q_data.y < min_y_q) ? q_data.y : min_y_q;
			max_y_d = (q_data.y > max_y_q) ? q_data.y : max_y_q;
		end

		do_open   = 1'b0;
		do_err    = 1'b0;
		do_peak   = 1'b0;
		do_change = 1'b0;
		do_flush  = 1'b0;
		do_start  = 1'b0;
		case (q_data.kind)
			KIND_SAMPLE: begin
				if (fresh_q) begin
					do_open = 1'b1;
				end else if (x_lt_prev) begin
					do_err = 1'b1;
				end else if (!open_q) begin
					do_open = 1'b1;
				end else if (same_bin) begin
					do_peak = 1'b1;
				end else begin
					do_change = 1'b1;
				end
			end
			KIND_START: begin
				do_start = 1'b1;
			end
			KIND_FLUSH: begin
				do_flush = open_q;
			end
			default: begin
			end
		endcase
	end

	// result sequencing
	always_comb begin
		out_free    = !out_valid_q || out_ready;
		use_new_ext = (state_q == B_IDLE) && k_sample;
		q_pop       = 1'b0;
		load        = 1'b0;
		peak_commit = 1'b0;
		state_d     = state_q;

		res_d.point_valid = 1'b0;
		res_d.point_x     = '0;
		res_d.point_y     = '0;
		res_d.last        = 1'b1;
		res_d.status      = ((state_q == B_IDLE) && do_err) ? STATUS_DROP : STATUS_OK;
		res_d.seen_min_x  = use_new_ext ? min_x_d : min_x_q;
		res_d.seen_max_x  = use_new_ext ? max_x_d : max_x_q;
		res_d.seen_min_y  = use_new_ext ? min_y_d : min_y_q;
		res_d.seen_max_y  = use_new_ext ? max_y_d : max_y_q;

		case (state_q)
			B_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					load  = 1'b1;
					if (do_change || do_flush) begin
						res_d.point_valid = 1'b1;
						res_d.point_x     = col_x_q;
						res_d.last        = 1'b0;
						state_d           = B_EMIT1;
					end else if (do_open) begin
						state_d = B_MUL;
					end
				end
			end
			B_EMIT1: begin
				res_d.point_valid = 1'b1;
				res_d.point_x     = col_x_q;
				res_d.point_y     = col_peak_q;
				res_d.last        = 1'b0;
				if (out_free) begin
					load    = 1'b1;
					state_d = B_EMIT2;
				end
			end
			B_EMIT2: begin
				res_d.point_valid = 1'b1;
				res_d.point_x     = col_x_q;
				if (out_free) begin
					load        = 1'b1;
					peak_commit = chg_q;
					state_d     = chg_q ? B_MUL : B_IDLE;
				end
			end
			B_MUL: begin
				state_d = B_RND;
			end
			B_RND: begin
				state_d = B_COLX;
			end
			B_COLX: begin
				state_d = B_IDLE;
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// column x: round the scaled bin, clamp, then offset from origin and clamp
	always_comb begin
		rsum      = {1'b0, prod_q} + HALF_B;
		rval      = rsum[PB_W:FRAC_BITS];
		org_ext   = {{(CXS_W - SAMPLE_BITS){cfg.origin[SAMPLE_BITS-1]}}, cfg.origin};
		off_ext   = {1'b0, sat_q};
		colx_sum  = col_neg_q ? (org_ext - off_ext) : (org_ext + off_ext);
		colx_fits = colx_sum[CXS_W-1:SAMPLE_BITS-1] ==
			{(CXS_W - SAMPLE_BITS + 1){colx_sum[CXS_W-1]}};
		if (colx_fits) begin
			colx_d = colx_sum[SAMPLE_BITS-1:0];
		end else if (colx_sum[CXS_W-1]) begin
			colx_d = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
		end else begin
			colx_d = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q     <= 1'b1;
			open_q      <= 1'b0;
			chg_q       <= 1'b0;
			prev_x_q    <= '0;
			col_neg_q   <= 1'b0;
			col_mag_q   <= '0;
			col_x_q     <= '0;
			col_peak_q  <= '0;
			pend_y_q    <= '0;
			min_x_q     <= '0;
			max_x_q     <= '0;
			min_y_q     <= '0;
			max_y_q     <= '0;
			prod_q      <= '0;
			sat_q       <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (q_pop) begin
				if (k_sample) begin
					fresh_q <= 1'b0;
					min_x_q <= min_x_d;
					max_x_q <= max_x_d;
					min_y_q <= min_y_d;
					max_y_q <= max_y_d;
				end
				if (do_start) begin
					fresh_q <= 1'b1;
					open_q  <= 1'b0;
				end
				if (do_open || do_change || do_peak) begin
					prev_x_q <= q_data.x;
				end
				if (do_open || do_change) begin
					open_q    <= 1'b1;
					col_neg_q <= q_data.bin_neg;
					col_mag_q <= q_data.bin_mag;
				end
				if (do_open) begin
					col_peak_q <= q_data.y;
				end
				if (do_peak && (q_data.y > col_peak_q)) begin
					col_peak_q <= q_data.y;
				end
				if (do_change || do_flush) begin
					chg_q    <= do_change;
					pend_y_q <= q_data.y;
				end
			end
			// the closed column has been sent, new column takes the pending peak
			if (peak_commit) begin
				col_peak_q <= pend_y_q;
			end
			if (state_q == B_MUL) begin
				prod_q <= PB_W'(col_mag_q) * PB_W'(cfg.step);
			end
			if (state_q == B_RND) begin
				sat_q <= (rval > RB_W'(COLX_LIM)) ? COLX_LIM : rval[CXM_W-1:0];
			end
			if (state_q == B_COLX) begin
				col_x_q <= colx_d;
			end
			if (load) begin
				out_valid_q <= 1'b1;
				res_q       <= res_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_emit_needs_column: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT1 || state_q == B_EMIT2) |-> open_q)
		else $error("column sent while no column open");

	a_drop_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status == STATUS_DROP) |-> (!res_q.point_valid && res_q.last))
		else $error("dropped sample carries a point");

	a_change_recomputes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT2 && load && chg_q) |=> (state_q == B_MUL))
		else $error("column change without new column x");

	a_colx_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_COLX) |=> (state_q == B_IDLE && open_q))
		else $error("column x step left sequencer in wrong state");

endmodule

FILE: rtl/pixel_column_peak_decimator.sv
// ----------------------------------------------------------------------------
// pixel_column_peak_decimator: column peak decimation for waveform plots
// snaps samples to pixel columns and emits each closed column as a fill-under triple
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): one request per handshake, kind selects
//   sample, start of a new series, or flush of the open column
//   output channel (out_valid/out_ready): every request gives one result, or
//   three results (point_valid set, last on the third) when a column is sent
//   config port: cfg_write with cfg_index/cfg_data, taken at once; the user must
//   write only while idle, the block itself does not enforce it
// request handling
//   a request passes both front stages and the queue before the output register; one
//   that sends no column or only updates it keeps the back end idle; a new column
//   runs the multiply, round and offset of the column x, after the triple on a
//   change; the single output register passes at most one result per cycle
// reset
//   arst_n clears the pipeline, the queue and the series state: fresh series,
//   no open column, extremes at zero; registers return to origin 0, scale and
//   step 1.0 in q16.16
// stalls
//   with out_ready low the back end holds, the 4 entry queue fills, then the
//   two front stages stop and in_ready drops
// ----------------------------------------------------------------------------
module pixel_column_peak_decimator import pcpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// register writes
	input  logic                 cfg_write,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// request channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           kind,
	input  sample_t              x_value,
	input  sample_t              y_value,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 point_valid,
	output sample_t              point_x,
	output sample_t              point_y,
	output logic                 last,
	output logic                 status,
	output sample_t              seen_min_x,
	output sample_t              seen_max_x,
	output sample_t              seen_min_y,
	output sample_t              seen_max_y
);

	cfg_t    cfg_q;
	logic    q_push;
	cmd_t    q_wdata;
	logic    q_ready;
	logic    q_valid;
	cmd_t    q_rdata;
	logic    q_pop;
	result_t res;

	// configuration registers, written directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin <= '0;
			cfg_q.scale  <= SCALE_RST;
			cfg_q.step   <= SCALE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_X_ORIGIN: begin
					cfg_q.origin <= cfg_data[SAMPLE_BITS-1:0];
				end
				REG_BIN_SCALE: begin
					cfg_q.scale <= cfg_data[SCALE_W-1:0];
				end
				REG_BIN_STEP: begin
					cfg_q.step <= cfg_data[SCALE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// front end: takes requests and computes the pixel bin
	pcpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.x_value  (x_value),
		.y_value  (y_value),
		.q_push   (q_push),
		.q_wdata  (q_wdata),
		.q_ready  (q_ready)
	);

	// decouples bin math from column sequencing
	pcpd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.ready  (q_ready),
		.valid  (q_valid),
		.rdata  (q_rdata),
		.pop    (q_pop)
	);

	// back end: series state, column peak, result sequencing
	pcpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	// result record onto the output ports
	assign point_valid = res.point_valid;
	assign point_x     = res.point_x;
	assign point_y     = res.point_y;
	assign last        = res.last;
	assign status      = res.status;
	assign seen_min_x  = res.seen_min_x;
	assign seen_max_x  = res.seen_max_x;
	assign seen_min_y  = res.seen_min_y;
	assign seen_max_y  = res.seen_max_y;

endmodule
